### design/binary_to_decimal_ascii_core_assert.svh
// Assertion macros for the binary to decimal ASCII core.
// Included by the top level; needs no other file.
`ifndef BINARY_TO_DECIMAL_ASCII_CORE_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define B2DA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("b2da assertion failed");

// Next-cycle implication, disabled during reset.
`define B2DA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("b2da assertion failed");

`endif

### design/b2da_pkg.sv
// Shared types and constants for the binary to decimal ASCII core.
// No dependencies.
package b2da_pkg;

  localparam int unsigned WideBits  = 32;
  localparam int unsigned ByteBits  = 8;
  localparam int unsigned NumDigits = 10;
  localparam int unsigned WideTop   = 9;
  localparam int unsigned ByteTop   = 2;
  localparam int unsigned CntW      = 6;
  localparam int unsigned IdxW      = 4;
  localparam logic [5:0]  AsciiZero = 6'h30;

  typedef struct packed {
    logic [31:0] value;
    logic        wide_mode;
    logic        keep_leading_zeros;
  } b2da_in_t;

  typedef struct packed {
    logic [5:0] digit_char;
    logic       last;
  } b2da_out_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic skip;
    logic emit;
  } b2da_cmd_t;

  typedef struct packed {
    logic shift_done;
    logic skip_ok;
    logic idx_zero;
    logic out_free;
  } b2da_sts_t;

endpackage

### design/b2da_ctrl.sv
// Controller for the binary to decimal ASCII core: accept, convert, emit.
// Depends on b2da_pkg.
module b2da_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  b2da_pkg::b2da_sts_t sts_i,
  output b2da_pkg::b2da_cmd_t cmd_o
);
  import b2da_pkg::*;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StConv = 3'b010,
    StEmit = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StConv;
        end
      end
      StConv: begin
        cmd_o.shift = 1'b1;
        if (sts_i.shift_done) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (sts_i.skip_ok) begin
          cmd_o.skip = 1'b1;
        end else if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.idx_zero) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### design/b2da_dp.sv
// Datapath for the binary to decimal ASCII core: shift-add-3 BCD conversion,
// digit selection and output register. Depends on b2da_pkg.
module b2da_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  b2da_pkg::b2da_in_t  in_data_i,
  input  b2da_pkg::b2da_cmd_t cmd_i,
  output b2da_pkg::b2da_sts_t sts_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output b2da_pkg::b2da_out_t out_data_o
);
  import b2da_pkg::*;

  logic [WideBits-1:0]    bin_q, bin_d;
  logic [4*NumDigits-1:0] bcd_q, bcd_d, adj;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [IdxW-1:0]        idx_q, idx_d;
  logic                   supp_q, supp_d;
  logic                   out_valid_q, out_valid_d;
  b2da_out_t              out_q, out_d;
  logic [3:0]             digit;
  logic [WideBits-1:0]    masked;

  assign masked = in_data_i.wide_mode ? in_data_i.value
                                      : {{(WideBits-ByteBits){1'b0}},
                                         in_data_i.value[ByteBits-1:0]};

  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                 : bcd_q[4*i +: 4];
    end
  end

  assign digit = bcd_q[4*idx_q +: 4];

  assign sts_o.shift_done = (cnt_q == CntW'(1));
  assign sts_o.skip_ok    = supp_q && (digit == 4'd0) && (idx_q != '0);
  assign sts_o.idx_zero   = (idx_q == '0);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    bin_d       = bin_q;
    bcd_d       = bcd_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    supp_d      = supp_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.load) begin
      bin_d  = in_data_i.wide_mode ? masked : (masked << (WideBits - ByteBits));
      bcd_d  = '0;
      cnt_d  = in_data_i.wide_mode ? CntW'(WideBits) : CntW'(ByteBits);
      idx_d  = in_data_i.wide_mode ? IdxW'(WideTop) : IdxW'(ByteTop);
      supp_d = !in_data_i.keep_leading_zeros || (masked == '0);
    end
    if (cmd_i.shift) begin
      bcd_d = {adj[4*NumDigits-2:0], bin_q[WideBits-1]};
      bin_d = {bin_q[WideBits-2:0], 1'b0};
      cnt_d = cnt_q - CntW'(1);
    end
    if (cmd_i.skip) begin
      idx_d = idx_q - IdxW'(1);
    end
    if (cmd_i.emit) begin
      out_d.digit_char = AsciiZero + {2'b00, digit};
      out_d.last       = (idx_q == '0);
      out_valid_d      = 1'b1;
      supp_d           = 1'b0;
      idx_d            = idx_q - IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q  <= bin_d;
    bcd_q  <= bcd_d;
    idx_q  <= idx_d;
    supp_q <= supp_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### design/binary_to_decimal_ascii_core.sv
// Sequence: accept, shift-add-3 over the 8 (byte) or 32 (wide) input bits, then a
// skip per suppressed leading zero (up to 9) and an emit per digit sent; an emit
// waits while the one-entry output register is full and stalled.
// One number at a time in the single conversion register, until the last emit.
// Reset: asynchronous, active low; clears the controller, output valid and bit counter.
// Depends on b2da_pkg, b2da_ctrl, b2da_dp and the assertion macro header.
`include "binary_to_decimal_ascii_core_assert.svh"
module binary_to_decimal_ascii_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  b2da_pkg::b2da_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output b2da_pkg::b2da_out_t out_data_o
);
  import b2da_pkg::*;

  b2da_cmd_t cmd;
  b2da_sts_t sts;

  b2da_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  b2da_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  `B2DA_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `B2DA_ASSERT_SAME(a_emit_into_free_slot, clk_i, rst_ni, cmd.emit, sts.out_free)
  `B2DA_ASSERT_NEXT(a_idle_after_final, clk_i, rst_ni, cmd.emit && sts.idx_zero, !in_stall_o)

endmodule
